[rtl/tmr_pkg.sv]
// Shared types, codes and constants of the prescaled multi-channel timer.
`default_nettype none

package tmr_pkg;

    // Default sizes of the block.
    localparam int DEF_NUM_CHANNELS  = 4;
    localparam int DEF_PRESCALE_BITS = 16;
    localparam int DATA_W            = 32;
    localparam int WORD_W            = 5;
    localparam int ACTION_W          = 2;
    localparam int MASK_W            = 4;

    // Codes of the action field.
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd2;

    // Register words below the channel block.
    localparam logic [WORD_W-1:0] WORD_SCALER     = 5'd0;
    localparam logic [WORD_W-1:0] WORD_SCALER_RLD = 5'd1;
    localparam logic [WORD_W-1:0] WORD_CAPABILITY = 5'd2;

    // Register within a channel, from the low two bits of the word.
    localparam logic [1:0] CH_REG_COUNT   = 2'd0;
    localparam logic [1:0] CH_REG_RELOAD  = 2'd1;
    localparam logic [1:0] CH_REG_CONTROL = 2'd2;

    // Bus view of the control register.
    localparam int CTL_BIT_EN    = 0;
    localparam int CTL_BIT_RS    = 1;
    localparam int CTL_BIT_LOAD  = 2;
    localparam int CTL_BIT_IE    = 3;
    localparam int CTL_BIT_IP    = 4;
    localparam int CTL_BIT_CHAIN = 5;
    localparam int CTL_READ_W    = 6;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_INDEX_W-1:0] CFG_IRQ_NUMBER    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEPARATE_IRQS = 1'b1;
    localparam logic [4:0] IRQ_NUMBER_RESET    = 5'd8;
    localparam logic       SEPARATE_IRQS_RESET = 1'b1;

    // Stored control bits of one channel.
    typedef struct packed {
        logic chain;
        logic ip;
        logic ie;
        logic rs;
        logic en;
    } tmr_ctrl_t;

    // Strobes into the prescaler for one accepted word.
    typedef struct packed {
        logic tick;
        logic wr_count;
        logic wr_reload;
    } tmr_pre_cmd_t;

    // Strobes into one channel for one accepted word.
    typedef struct packed {
        logic tick;
        logic wr_count;
        logic wr_reload;
        logic wr_ctrl;
    } tmr_chan_cmd_t;

    // Read-back and status of one channel.
    typedef struct packed {
        logic [DATA_W-1:0]     count;
        logic [DATA_W-1:0]     reload;
        logic [CTL_READ_W-1:0] ctrl_read;
        logic                  ip_next;
        logic                  underflow;
    } tmr_chan_stat_t;

endpackage

`default_nettype wire

[rtl/tmr_prescaler.sv]
// Shared prescaler: a down counter that reloads and pulses on underflow.
`default_nettype none

module tmr_prescaler #(
    parameter int PRESCALE_BITS = tmr_pkg::DEF_PRESCALE_BITS
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire tmr_pkg::tmr_pre_cmd_t  cmd,
    input  wire [PRESCALE_BITS-1:0]     wdata,
    output logic                        pulse,
    output logic [PRESCALE_BITS-1:0]    count,
    output logic [PRESCALE_BITS-1:0]    reload
);
    import tmr_pkg::*;

    logic [PRESCALE_BITS-1:0] count_reg;
    logic [PRESCALE_BITS-1:0] count_next;
    logic [PRESCALE_BITS-1:0] reload_reg;
    logic [PRESCALE_BITS-1:0] reload_next;

    // Count down on a tick, reload and pulse at zero; bus writes override.
    always_comb
    begin
        count_next  = count_reg;
        reload_next = reload_reg;
        pulse       = 1'b0;
        if (cmd.tick)
        begin
            if (count_reg == '0)
            begin
                count_next = reload_reg;
                pulse      = 1'b1;
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
        if (cmd.wr_count)
        begin
            count_next = wdata;
        end
        if (cmd.wr_reload)
        begin
            reload_next = wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            reload_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
        end
    end

    assign count  = count_reg;
    assign reload = reload_reg;

endmodule

`default_nettype wire

[rtl/tmr_channel.sv]
// One down-counting timer channel with reload, chaining and pending flag.
`default_nettype none

module tmr_channel #(
    parameter bit CHAIN_OK = 1'b1
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire tmr_pkg::tmr_chan_cmd_t  cmd,
    input  wire [tmr_pkg::DATA_W-1:0]    wdata,
    input  wire                          pulse,
    input  wire                          prev_underflow,
    output tmr_pkg::tmr_chan_stat_t      stat
);
    import tmr_pkg::*;

    logic [DATA_W-1:0] count_reg;
    logic [DATA_W-1:0] count_next;
    logic [DATA_W-1:0] reload_reg;
    logic [DATA_W-1:0] reload_next;
    tmr_ctrl_t         ctrl_reg;
    tmr_ctrl_t         ctrl_next;
    logic              trig;
    logic              under;

    // The first channel has no predecessor and always counts on the prescaler.
    assign trig  = (CHAIN_OK && ctrl_reg.chain) ? prev_underflow : pulse;
    assign under = cmd.tick && ctrl_reg.en && trig && (count_reg == '0);

    // Next counter, reload and control state for this word.
    always_comb
    begin
        count_next  = count_reg;
        reload_next = reload_reg;
        ctrl_next   = ctrl_reg;
        if (cmd.tick && ctrl_reg.en && trig)
        begin
            if (count_reg == '0)
            begin
                if (ctrl_reg.ie)
                begin
                    ctrl_next.ip = 1'b1;
                end
                if (ctrl_reg.rs)
                begin
                    count_next = reload_reg;
                end
                else
                begin
                    count_next   = '1;
                    ctrl_next.en = 1'b0;
                end
            end
            else
            begin
                count_next = count_reg - 1'b1;
            end
        end
        if (cmd.wr_count)
        begin
            count_next = wdata;
        end
        if (cmd.wr_reload)
        begin
            reload_next = wdata;
        end
        if (cmd.wr_ctrl)
        begin
            ctrl_next.en    = wdata[CTL_BIT_EN];
            ctrl_next.rs    = wdata[CTL_BIT_RS];
            ctrl_next.ie    = wdata[CTL_BIT_IE];
            ctrl_next.chain = wdata[CTL_BIT_CHAIN];
            ctrl_next.ip    = ctrl_reg.ip && !wdata[CTL_BIT_IP];
            if (wdata[CTL_BIT_LOAD])
            begin
                count_next = reload_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            reload_reg <= '0;
            ctrl_reg   <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            reload_reg <= reload_next;
            ctrl_reg   <= ctrl_next;
        end
    end

    // Status and read-back; the load bit always reads as zero.
    always_comb
    begin
        stat.count     = count_reg;
        stat.reload    = reload_reg;
        stat.ctrl_read = '0;
        stat.ctrl_read[CTL_BIT_EN]    = ctrl_reg.en;
        stat.ctrl_read[CTL_BIT_RS]    = ctrl_reg.rs;
        stat.ctrl_read[CTL_BIT_IE]    = ctrl_reg.ie;
        stat.ctrl_read[CTL_BIT_IP]    = ctrl_reg.ip;
        stat.ctrl_read[CTL_BIT_CHAIN] = ctrl_reg.chain;
        stat.ip_next   = ctrl_next.ip;
        stat.underflow = under;
    end

endmodule

`default_nettype wire

[rtl/prescaled_multi_channel_timer.sv]
// Timer unit with a shared prescaler and a row of chainable down counters.
//
// Usage: each word on the input channel (in_valid/in_ready) is a clock tick,
// a register read or a register write, chosen by action. Every accepted word
// gives exactly one result word on the output channel (out_valid/out_ready):
// read data, the pending flags after the word and the underflow mask.
// The word is applied to the timer state at the edge that accepts it, and its
// result stands in the output register from the next cycle. Throughput is one
// word per cycle while the receiver takes each result; the whole tick
// (prescaler, then every channel with chain ripple) is one pass of logic
// before the state and output registers.
// When the receiver stalls, the result is held and in_ready drops once the
// output register is full and not being taken; it rises again in the cycle
// the result is taken. Reset clears all counters, reloads and control bits,
// empties the output register and sets the interrupt number to eight with
// separate interrupts enabled. Configuration writes are registered.
`default_nettype none

module prescaled_multi_channel_timer #(
    parameter int NUM_CHANNELS  = tmr_pkg::DEF_NUM_CHANNELS,
    parameter int PRESCALE_BITS = tmr_pkg::DEF_PRESCALE_BITS
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               cfg_write_en,
    input  wire [tmr_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire [tmr_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire                               in_valid,
    output logic                              in_ready,
    input  wire [tmr_pkg::ACTION_W-1:0]       action,
    input  wire [tmr_pkg::WORD_W-1:0]         reg_word,
    input  wire [tmr_pkg::DATA_W-1:0]         write_value,
    output logic                              out_valid,
    input  wire                               out_ready,
    output logic [tmr_pkg::DATA_W-1:0]        read_data,
    output logic [tmr_pkg::MASK_W-1:0]        pending_mask,
    output logic [tmr_pkg::MASK_W-1:0]        underflow_mask
);
    import tmr_pkg::*;

    logic                     accept;
    logic                     acc_tick;
    logic                     acc_read;
    logic                     acc_write;
    logic [4:0]               irq_number_reg;
    logic                     separate_irqs_reg;
    tmr_pre_cmd_t             pre_cmd;
    logic                     pre_pulse;
    logic [PRESCALE_BITS-1:0] pre_count;
    logic [PRESCALE_BITS-1:0] pre_reload;
    tmr_chan_cmd_t            chan_cmd  [NUM_CHANNELS];
    tmr_chan_stat_t           chan_stat [NUM_CHANNELS];
    logic [DATA_W-1:0]        chan_rd   [NUM_CHANNELS];
    logic [NUM_CHANNELS:0]    uf_chain;
    logic [1:0]               ch_reg;
    logic [DATA_W-1:0]        cap_word;
    logic [DATA_W-1:0]        rd_value;
    logic [MASK_W-1:0]        pend_value;
    logic [MASK_W-1:0]        uf_value;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [DATA_W-1:0]        read_data_reg;
    logic [MASK_W-1:0]        pending_mask_reg;
    logic [MASK_W-1:0]        underflow_mask_reg;

    // Handshake: a new word is taken whenever the result register frees up.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign acc_tick  = accept && (action == ACT_TICK);
    assign acc_read  = accept && (action == ACT_READ);
    assign acc_write = accept && (action == ACT_WRITE);
    assign ch_reg    = reg_word[1:0];

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_number_reg    <= IRQ_NUMBER_RESET;
            separate_irqs_reg <= SEPARATE_IRQS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_IRQ_NUMBER:    irq_number_reg    <= cfg_data[4:0];
                CFG_SEPARATE_IRQS: separate_irqs_reg <= cfg_data[0];
                default:           irq_number_reg    <= irq_number_reg;
            endcase
        end
    end

    // Prescaler.
    assign pre_cmd.tick      = acc_tick;
    assign pre_cmd.wr_count  = acc_write && (reg_word == WORD_SCALER);
    assign pre_cmd.wr_reload = acc_write && (reg_word == WORD_SCALER_RLD);

    tmr_prescaler #(
        .PRESCALE_BITS (PRESCALE_BITS)
    ) u_prescaler (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (pre_cmd),
        .wdata  (write_value[PRESCALE_BITS-1:0]),
        .pulse  (pre_pulse),
        .count  (pre_count),
        .reload (pre_reload)
    );

    // Channels; the underflow of each one feeds the chain input of the next.
    assign uf_chain[0] = 1'b0;

    for (genvar i = 0; i < NUM_CHANNELS; i++)
    begin : g_chan
        logic sel;

        // Channel i owns words 4+4i to 7+4i.
        assign sel = (reg_word[4:2] == 3'(i + 1));

        assign chan_cmd[i].tick      = acc_tick;
        assign chan_cmd[i].wr_count  = acc_write && sel && (ch_reg == CH_REG_COUNT);
        assign chan_cmd[i].wr_reload = acc_write && sel && (ch_reg == CH_REG_RELOAD);
        assign chan_cmd[i].wr_ctrl   = acc_write && sel && (ch_reg == CH_REG_CONTROL);

        tmr_channel #(
            .CHAIN_OK (i != 0)
        ) u_channel (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (chan_cmd[i]),
            .wdata          (write_value),
            .pulse          (pre_pulse),
            .prev_underflow (uf_chain[i]),
            .stat           (chan_stat[i])
        );

        assign uf_chain[i+1] = chan_stat[i].underflow;

        // Read-back of this channel, zero when not addressed.
        always_comb
        begin
            chan_rd[i] = '0;
            if (sel)
            begin
                case (ch_reg)
                    CH_REG_COUNT:   chan_rd[i] = chan_stat[i].count;
                    CH_REG_RELOAD:  chan_rd[i] = chan_stat[i].reload;
                    CH_REG_CONTROL: chan_rd[i] = DATA_W'(chan_stat[i].ctrl_read);
                    default:        chan_rd[i] = '0;
                endcase
            end
        end
    end

    // Pending and underflow masks cover the first four channels only.
    for (genvar j = 0; j < MASK_W; j++)
    begin : g_mask
        if (j < NUM_CHANNELS)
        begin : g_used
            assign pend_value[j] = chan_stat[j].ip_next;
            assign uf_value[j]   = chan_stat[j].underflow;
        end
        else
        begin : g_unused
            assign pend_value[j] = 1'b0;
            assign uf_value[j]   = 1'b0;
        end
    end

    // Capability word.
    always_comb
    begin
        cap_word      = '0;
        cap_word[2:0] = 3'(NUM_CHANNELS - 1);
        cap_word[7:3] = irq_number_reg;
        cap_word[8]   = separate_irqs_reg;
    end

    // Read data multiplexer.
    always_comb
    begin
        rd_value = '0;
        if (acc_read)
        begin
            case (reg_word)
                WORD_SCALER:     rd_value = DATA_W'(pre_count);
                WORD_SCALER_RLD: rd_value = DATA_W'(pre_reload);
                WORD_CAPABILITY: rd_value = cap_word;
                default:
                begin
                    for (int n = 0; n < NUM_CHANNELS; n++)
                    begin
                        rd_value = rd_value | chan_rd[n];
                    end
                end
            endcase
        end
    end

    // Result register.
    assign out_valid_next = accept || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg      <= rd_value;
            pending_mask_reg   <= pend_value;
            underflow_mask_reg <= acc_tick ? uf_value : '0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_data      = read_data_reg;
    assign pending_mask   = pending_mask_reg;
    assign underflow_mask = underflow_mask_reg;

`ifndef SYNTHESIS
    // Every accepted word leaves a result behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

    // Only a tick can report an underflow.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action != ACT_TICK)) |=> (underflow_mask == '0))
        else $error("underflow reported for a non-tick word");

    // Only a read returns data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action != ACT_READ)) |=> (read_data == '0))
        else $error("read data nonzero for a non-read word");

    // A held result never takes a new word under it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("input taken while result is stalled");
`endif

endmodule

`default_nettype wire
